>>> src/multistage_range_remap_min_top_macros.svh
// Assertion macros for the multistage range remap block.
// Used by multistage_range_remap_min_top; expects clk and rst_n in scope.
`ifndef MULTISTAGE_RANGE_REMAP_MIN_TOP_MACROS_SVH
`define MULTISTAGE_RANGE_REMAP_MIN_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold on every clock outside reset
`define MRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define MRR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MRR_ASSERT(label, prop, msg)
`define MRR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> src/mrr_pkg.sv
// Shared types and constants for the multistage range remap block.
// No dependencies; imported by mrr_scan and the top level.
package mrr_pkg;

    // fixed widths of the port fields
    localparam int FIELD_W = 32;
    localparam int LEN_W   = 32;
    localparam int CFG_W   = 4;
    localparam logic [CFG_W-1:0] CFG_STAGES_RESET = 4'd7;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_LOAD      = 2'd1,
        CMD_MAP       = 2'd2,
        CMD_RESET_MIN = 2'd3
    } mrr_cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_FINISH,
        ST_INIT,
        ST_WIPE
    } mrr_state_t;

    // sequencer to scan unit controls
    typedef struct packed {
        logic load_value;
        logic clear_best;
        logic compare;
        logic apply;
    } mrr_scan_ctrl_t;

endpackage

>>> src/mrr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mrr_scan.sv
// Scan unit: checks one table entry per cycle against the current value,
// keeps the best match of the stage and applies it at stage end. Uses mrr_pkg.
module mrr_scan
    import mrr_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mrr_scan_ctrl_t                    ctrl,
    input  logic [VALUE_BITS-1:0]             query,
    input  logic [2*VALUE_BITS+LEN_W-1:0]     entry_word,
    input  logic                              entry_valid,
    output logic [VALUE_BITS-1:0]             value
);

    localparam int CW = (VALUE_BITS > LEN_W) ? VALUE_BITS : LEN_W;

    logic [VALUE_BITS-1:0] value_reg;
    logic                  found_reg;
    logic [VALUE_BITS-1:0] best_src_reg;
    logic [VALUE_BITS-1:0] best_dst_reg;

    logic [VALUE_BITS-1:0] ent_dst;
    logic [VALUE_BITS-1:0] ent_src;
    logic [LEN_W-1:0]      ent_len;
    logic [VALUE_BITS-1:0] offset;
    logic                  hit;
    logic                  better;

    // entry word layout: {dest, source, length}
    assign ent_dst = entry_word[2*VALUE_BITS+LEN_W-1:VALUE_BITS+LEN_W];
    assign ent_src = entry_word[VALUE_BITS+LEN_W-1:LEN_W];
    assign ent_len = entry_word[LEN_W-1:0];

    // match test: source <= value and value - source < length
    assign offset = value_reg - ent_src;
    assign hit    = entry_valid && (value_reg >= ent_src) && (CW'(offset) < CW'(ent_len));
    // strict compare keeps the lowest slot on equal sources
    assign better = !found_reg || (ent_src < best_src_reg);

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear_best)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.compare && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    // best entry and running value
    always_ff @(posedge clk)
    begin
        if (ctrl.compare && hit && better)
        begin
            best_src_reg <= ent_src;
            best_dst_reg <= ent_dst;
        end
        if (ctrl.load_value)
        begin
            value_reg <= query;
        end
        else if (ctrl.apply && found_reg)
        begin
            value_reg <= value_reg + best_dst_reg - best_src_reg;
        end
    end

    assign value = value_reg;

endmodule

>>> src/multistage_range_remap_min_top.sv
// Top level of the multistage range remap block with running minimum.
// Uses mrr_pkg, mrr_ram, mrr_scan and multistage_range_remap_min_top_macros.svh.
//
// Usage:
//   Items enter on item_valid/item_stall, one command per beat; every beat
//   gives exactly one result beat on result_valid/result_stall.
//   stages_in_use is written through cfg_valid/cfg_ready (always ready);
//   the user must write it only while the block is idle, the block itself
//   does not enforce this. Values above STAGES act as STAGES.
//   Entries and their valid bits share one memory. Load and reset-minimum
//   go from accept through the finish state to the result register. Clear
//   rewrites every slot, one per cycle, then finishes. A map reads each
//   active stage's entries one per cycle, then does the last compare (drain
//   state) and applies the match (apply state). One item is in work at a
//   time. A stalled result is held in the output register while the next
//   item is accepted and worked on. After reset item_stall stays high while
//   every slot is cleared; the minimum is all ones and stages_in_use is 7.
`include "multistage_range_remap_min_top_macros.svh"

module multistage_range_remap_min_top
    import mrr_pkg::*;
#(
    parameter int STAGES            = 8,
    parameter int ENTRIES_PER_STAGE = 32,
    parameter int VALUE_BITS        = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   stages_in_use,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         command,
    input  logic [2:0]         stage_index,
    input  logic [4:0]         entry_index,
    input  logic [FIELD_W-1:0] dest_start,
    input  logic [FIELD_W-1:0] source_start,
    input  logic [FIELD_W-1:0] range_length,
    input  logic [FIELD_W-1:0] query_value,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [FIELD_W-1:0] mapped_value,
    output logic [FIELD_W-1:0] running_minimum
);

    localparam int TOTAL = STAGES * ENTRIES_PER_STAGE;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SIW   = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int KW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int NW    = $clog2(STAGES + 1);
    localparam int MEM_W = 2 * VALUE_BITS + LEN_W;
    localparam int ENT_W = MEM_W + 1;
    localparam int WIDE  = VALUE_BITS + FIELD_W;

    mrr_state_t            state_reg, state_next;
    logic [SIW-1:0]        stage_reg, stage_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [AW-1:0]         wipe_reg, wipe_next;
    logic                  rd_pend_reg;
    mrr_cmd_t              cmd_reg;
    logic [CFG_W-1:0]      stages_reg;
    logic [VALUE_BITS-1:0] min_reg;
    logic                  result_valid_reg;
    logic [FIELD_W-1:0]    result_mapped_reg;
    logic [FIELD_W-1:0]    result_min_reg;

    logic                  item_fire;
    logic                  out_free;
    logic                  load_result;
    logic [NW-1:0]         n_eff;
    logic                  load_ok;
    logic                  load_we;
    logic                  wipe_we;
    logic                  ram_we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [ENT_W-1:0]      wdata;
    logic [ENT_W-1:0]      rdata;
    logic [WIDE-1:0]       dest_wide, source_wide, query_wide;
    logic [WIDE-1:0]       mapped_wide, min_wide;
    logic [VALUE_BITS-1:0] map_value;
    logic [VALUE_BITS-1:0] mapped_sel;
    logic [VALUE_BITS-1:0] new_min;
    mrr_scan_ctrl_t        scan_ctrl;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_fire  = item_valid && (state_reg == ST_IDLE);
    assign out_free   = !result_valid_reg || !result_stall;

    // active stage count, saturated to STAGES
    always_comb
    begin
        if (int'(stages_reg) > STAGES)
        begin
            n_eff = NW'(STAGES);
        end
        else
        begin
            n_eff = NW'(stages_reg);
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stages_reg <= CFG_STAGES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stages_reg <= stages_in_use;
        end
    end

    // field resizing to VALUE_BITS
    assign dest_wide   = WIDE'(dest_start);
    assign source_wide = WIDE'(source_start);
    assign query_wide  = WIDE'(query_value);

    // entry write: a load in idle, or the slot-by-slot clearing pass
    // loads and map reads never overlap, so no forwarding is needed
    assign load_ok = (int'(stage_index) < STAGES) && (int'(entry_index) < ENTRIES_PER_STAGE);
    assign load_we = item_fire && (command == CMD_LOAD) && load_ok;
    assign wipe_we = (state_reg == ST_INIT) || (state_reg == ST_WIPE);
    assign ram_we  = load_we || wipe_we;
    assign waddr   = wipe_we ? wipe_reg
                             : AW'(int'(stage_index) * ENTRIES_PER_STAGE + int'(entry_index));
    assign wdata   = wipe_we ? '0
                             : {1'b1, dest_wide[VALUE_BITS-1:0], source_wide[VALUE_BITS-1:0],
                                range_length};
    assign raddr   = AW'(int'(stage_reg) * ENTRIES_PER_STAGE + int'(k_reg));

    // entry word: {valid, dest, source, length}
    mrr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TOTAL)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mrr_scan #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .query       (query_wide[VALUE_BITS-1:0]),
        .entry_word  (rdata[MEM_W-1:0]),
        .entry_valid (rdata[MEM_W]),
        .value       (map_value)
    );

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            stage_reg   <= '0;
            k_reg       <= '0;
            wipe_reg    <= '0;
            rd_pend_reg <= 1'b0;
            cmd_reg     <= CMD_CLEAR;
        end
        else
        begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            k_reg       <= k_next;
            wipe_reg    <= wipe_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (item_fire)
            begin
                cmd_reg <= mrr_cmd_t'(command);
            end
        end
    end

    // sequencer next state and controls
    always_comb
    begin
        state_next           = state_reg;
        stage_next           = stage_reg;
        k_next               = k_reg;
        wipe_next            = wipe_reg;
        load_result          = 1'b0;
        scan_ctrl.load_value = 1'b0;
        scan_ctrl.clear_best = 1'b0;
        scan_ctrl.compare    = rd_pend_reg;
        scan_ctrl.apply      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    scan_ctrl.load_value = 1'b1;
                    scan_ctrl.clear_best = 1'b1;
                    stage_next           = '0;
                    k_next               = '0;
                    wipe_next            = '0;
                    if (command == CMD_CLEAR)
                    begin
                        state_next = ST_WIPE;
                    end
                    else if ((command == CMD_MAP) && (n_eff != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_INIT:
            begin
                if (int'(wipe_reg) == TOTAL - 1)
                begin
                    wipe_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wipe_next = wipe_reg + AW'(1);
                end
            end
            ST_WIPE:
            begin
                if (int'(wipe_reg) == TOTAL - 1)
                begin
                    wipe_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    wipe_next = wipe_reg + AW'(1);
                end
            end
            ST_SCAN:
            begin
                if (int'(k_reg) == ENTRIES_PER_STAGE - 1)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                scan_ctrl.apply      = 1'b1;
                scan_ctrl.clear_best = 1'b1;
                if (int'(stage_reg) == int'(n_eff) - 1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    stage_next = stage_reg + SIW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // running minimum and result values
    assign mapped_sel = (cmd_reg == CMD_MAP) ? map_value : '0;
    assign new_min    = ((cmd_reg == CMD_MAP) && (map_value < min_reg)) ? map_value : min_reg;
    assign mapped_wide = WIDE'(mapped_sel);
    assign min_wide    = WIDE'(new_min);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
        end
        else if (item_fire && ((command == CMD_CLEAR) || (command == CMD_RESET_MIN)))
        begin
            min_reg <= '1;
        end
        else if (load_result)
        begin
            min_reg <= new_min;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_mapped_reg <= mapped_wide[FIELD_W-1:0];
            result_min_reg    <= min_wide[FIELD_W-1:0];
        end
    end

    assign result_valid    = result_valid_reg;
    assign mapped_value    = result_mapped_reg;
    assign running_minimum = result_min_reg;

    // checks
    `MRR_ASSERT(a_write_only_idle, load_we |-> (state_reg == ST_IDLE), "entry write outside idle")
    `MRR_ASSERT(a_compare_after_read, rd_pend_reg |-> $past(state_reg == ST_SCAN), "compare without read")
    `MRR_ASSERT(a_finish_delivers, (state_reg == ST_FINISH && out_free) |=> (state_reg == ST_IDLE && result_valid_reg), "finish did not deliver")
    `MRR_ASSERT_NEVER(a_min_above_map, load_result && (cmd_reg == CMD_MAP) && (new_min > map_value), "minimum above mapped value")

endmodule

>>> bench/multistage_range_remap_min_top_tb.sv
// Self-checking bench for multistage_range_remap_min_top: range tables, map chain, running minimum.
// Depends on mrr_pkg and the block under test; compares every result beat against a local predictor.
// Stimulus runs directed cases, stage-count sweeps and random traffic with stalls on both sides.
module multistage_range_remap_min_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrr_pkg::*;

    localparam int N_STAGES       = 8;
    localparam int N_SLOTS        = 32;
    localparam int N_ENTRIES      = N_STAGES * N_SLOTS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int WINDOW_SPAN    = 2047;

    // one command beat
    typedef struct {
        mrr_cmd_t           cmd;
        logic [2:0]         stage;
        logic [4:0]         slot;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] query;
    } remap_item_t;

    // one result beat
    typedef struct {
        logic [FIELD_W-1:0] mapped;
        logic [FIELD_W-1:0] minimum;
    } remap_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   stages_in_use;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         command;
    logic [2:0]         stage_index;
    logic [4:0]         entry_index;
    logic [FIELD_W-1:0] dest_start;
    logic [FIELD_W-1:0] source_start;
    logic [FIELD_W-1:0] range_length;
    logic [FIELD_W-1:0] query_value;
    logic               result_valid;
    logic               result_stall;
    logic [FIELD_W-1:0] mapped_value;
    logic [FIELD_W-1:0] running_minimum;

    // predictor state
    logic [FIELD_W-1:0] tbl_dst   [N_ENTRIES];
    logic [FIELD_W-1:0] tbl_src   [N_ENTRIES];
    logic [FIELD_W-1:0] tbl_len   [N_ENTRIES];
    logic               tbl_valid [N_ENTRIES];
    logic [FIELD_W-1:0] low_water;
    logic [CFG_W-1:0]   cur_stage_count;

    remap_result_t      expected_results[$];
    int                 failures;
    bit                 idle_on;
    logic [FIELD_W-1:0] win_base;

    multistage_range_remap_min_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .stages_in_use   (stages_in_use),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .command         (command),
        .stage_index     (stage_index),
        .entry_index     (entry_index),
        .dest_start      (dest_start),
        .source_start    (source_start),
        .range_length    (range_length),
        .query_value     (query_value),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .mapped_value    (mapped_value),
        .running_minimum (running_minimum)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one stage lookup: smallest matching source start wins, lowest slot on ties
    function automatic logic [FIELD_W-1:0] translate_stage_value(input int stage,
                                                                 input logic [FIELD_W-1:0] v);
        logic               hit;
        logic [FIELD_W-1:0] best_src;
        logic [FIELD_W-1:0] best_dst;
        logic [FIELD_W-1:0] off;
        int                 k;
        int                 e;
        hit      = 1'b0;
        best_src = '0;
        best_dst = '0;
        for (k = 0; k < N_SLOTS; k++)
        begin
            e   = stage * N_SLOTS + k;
            off = v - tbl_src[e];
            // no wrap: value below source never matches
            if (tbl_valid[e] && v >= tbl_src[e] && off < tbl_len[e])
            begin
                if (!hit || tbl_src[e] < best_src)
                begin
                    hit      = 1'b1;
                    best_src = tbl_src[e];
                    best_dst = tbl_dst[e];
                end
            end
        end
        if (!hit)
            return v;
        return v + best_dst - best_src;
    endfunction

    // apply one command to the predictor and return the beat it should produce
    function automatic remap_result_t predict_command(input remap_item_t it);
        remap_result_t      r;
        logic [FIELD_W-1:0] v;
        int                 e;
        int                 n;
        int                 s;
        r.mapped = '0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                for (e = 0; e < N_ENTRIES; e++)
                    tbl_valid[e] = 1'b0;
                low_water = '1;
            end
            CMD_LOAD:
            begin
                e            = int'(it.stage) * N_SLOTS + int'(it.slot);
                tbl_dst[e]   = it.dst;
                tbl_src[e]   = it.src;
                tbl_len[e]   = it.len;
                tbl_valid[e] = 1'b1;
            end
            CMD_MAP:
            begin
                // stage counts above the table count saturate
                n = (int'(cur_stage_count) > N_STAGES) ? N_STAGES : int'(cur_stage_count);
                v = it.query;
                for (s = 0; s < n; s++)
                    v = translate_stage_value(s, v);
                if (v < low_water)
                    low_water = v;
                r.mapped = v;
            end
            default:
                low_water = '1;
        endcase
        r.minimum = low_water;
        return r;
    endfunction

    // random content on every field
    function automatic remap_item_t random_fields();
        remap_item_t it;
        it.cmd   = mrr_cmd_t'($urandom_range(0, 3));
        it.stage = 3'($urandom);
        it.slot  = 5'($urandom);
        it.dst   = $urandom;
        it.src   = $urandom;
        it.len   = $urandom;
        it.query = $urandom;
        return it;
    endfunction

    // drive one command beat and hold it until accepted
    task automatic send_item(input remap_item_t it);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        command      <= it.cmd;
        stage_index  <= it.stage;
        entry_index  <= it.slot;
        dest_start   <= it.dst;
        source_start <= it.src;
        range_length <= it.len;
        query_value  <= it.query;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_command(it));
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_results_done();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // write the stage count; block must be idle
    task automatic write_stage_count(input logic [CFG_W-1:0] n);
        cfg_valid     <= 1'b1;
        stages_in_use <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_stage_count = n;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_entry(input int stage, input int slot, input logic [FIELD_W-1:0] dst,
                              input logic [FIELD_W-1:0] src, input logic [FIELD_W-1:0] len);
        remap_item_t it;
        it       = random_fields();
        it.cmd   = CMD_LOAD;
        it.stage = 3'(stage);
        it.slot  = 5'(slot);
        it.dst   = dst;
        it.src   = src;
        it.len   = len;
        send_item(it);
    endtask

    task automatic map_value(input logic [FIELD_W-1:0] v);
        remap_item_t it;
        it       = random_fields();
        it.cmd   = CMD_MAP;
        it.query = v;
        send_item(it);
    endtask

    task automatic plain_cmd(input mrr_cmd_t c);
        remap_item_t it;
        it     = random_fields();
        it.cmd = c;
        send_item(it);
    endtask

    // write every entry once so no lookup ever touches unwritten memory, then clear
    task automatic test_fill_tables();
        int s;
        int k;
        for (s = 0; s < N_STAGES; s++)
            for (k = 0; k < N_SLOTS; k++)
                load_entry(s, k, $urandom, $urandom, $urandom);
        plain_cmd(CMD_CLEAR);
    endtask

    // hand-picked corner cases at the reset stage count
    task automatic test_directed_cases();
        map_value(32'hFFFF_FFFF);                       // empty tables pass through
        map_value(32'h0000_0000);
        plain_cmd(CMD_RESET_MIN);
        load_entry(0, 0, 32'd200, 32'd100, 32'd10);
        map_value(32'd100);                             // first value of range
        map_value(32'd109);                             // last value of range
        map_value(32'd110);                             // one past the end
        load_entry(0, 1, 32'd0, 32'd500, 32'd0);        // zero length never hits
        map_value(32'd500);
        // range running past the top does not wrap to low values
        load_entry(1, 31, 32'h10, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        map_value(32'hFFFF_FFF8);
        map_value(32'd5);
        load_entry(2, 0, 32'hFFFF_FFFF, 32'd0, 32'd4); // offset add wraps mod 2^32
        map_value(32'd2);
        // overlap: smaller source start wins over lower slot
        load_entry(3, 5, 32'd5000, 32'd1000, 32'd100);
        load_entry(3, 2, 32'd7000, 32'd1010, 32'd100);
        map_value(32'd1050);
        // equal source starts: lower slot wins
        load_entry(4, 7, 32'd3000, 32'd2000, 32'd10);
        load_entry(4, 3, 32'd4000, 32'd2000, 32'd20);
        map_value(32'd2005);
        // chain through several stages, last stage only active with 8
        load_entry(0, 2, 32'h5000, 32'h4000, 32'd16);
        load_entry(5, 0, 32'h6000, 32'h5000, 32'd16);
        load_entry(6, 31, 32'h7000, 32'h6000, 32'd16);
        load_entry(7, 0, 32'h0, 32'h7000, 32'd16);
        map_value(32'h4003);
    endtask

    // stage count sweep over the directed tables
    task automatic test_stage_counts();
        logic [CFG_W-1:0] counts [5];
        int               i;
        counts = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd9};
        for (i = 0; i < 5; i++)
        begin
            wait_results_done();
            write_stage_count(counts[i]);
            map_value(32'h4003);
            map_value(32'd1050);
        end
        plain_cmd(CMD_CLEAR);
        map_value(32'h4003);                            // cleared tables pass through
        wait_results_done();
        write_stage_count(CFG_STAGES_RESET);
    endtask

    // sender holds off until the block has drained, then resumes
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 4; i++)
            map_value($urandom);
        wait_results_done();
        repeat ($urandom_range(1, 19)) @(posedge clk);
        for (i = 0; i < 4; i++)
            map_value($urandom);
    endtask

    // random traffic: mostly dense tables in a small window so chains hit
    task automatic run_random_phase(input int n_items, input logic [CFG_W-1:0] stage_cfg);
        remap_item_t it;
        int          i;
        int          roll;
        bit          dense;
        wait_results_done();
        write_stage_count(stage_cfg);
        case ($urandom_range(0, 2))
            0:       win_base = '0;
            1:       win_base = 32'hFFFF_F800;             // window reaches up to the top value
            default: win_base = $urandom;
        endcase
        for (i = 0; i < n_items; i++)
        begin
            it    = random_fields();
            roll  = $urandom_range(0, 99);
            dense = ($urandom_range(0, 4) != 0);
            if (roll < 1)
                it.cmd = CMD_CLEAR;
            else if (roll < 5)
                it.cmd = CMD_RESET_MIN;
            else if (roll < 40)
            begin
                it.cmd = CMD_LOAD;
                if (dense)
                begin
                    it.src = win_base + $urandom_range(0, WINDOW_SPAN);
                    it.dst = win_base + $urandom_range(0, WINDOW_SPAN);
                    it.len = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 512);
                end
                else if ($urandom_range(0, 3) == 0)
                    it.len = '1;
            end
            else
            begin
                it.cmd = CMD_MAP;
                if (dense)
                    it.query = win_base + $urandom_range(0, WINDOW_SPAN);
                else if ($urandom_range(0, 3) == 0)
                    it.query = $urandom_range(0, 1) ? '1 : '0;
            end
            if ($urandom_range(0, 39) == 0)
                wait_results_done();
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(100, 4'd7);
        run_random_phase(100, 4'd8);
        run_random_phase(70, 4'd15);
        run_random_phase(70, 4'd3);
        run_random_phase(30, 4'd0);
        run_random_phase(100, 4'($urandom_range(0, 15)));
        // closing stretch with no idling on either side
        idle_on = 1'b0;
        run_random_phase(130, 4'd8);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_beat
        remap_result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat mapped %h minimum %h",
                         $time, mapped_value, running_minimum);
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (mapped_value !== exp_r.mapped)
                begin
                    $display("%0t: mapped_value mismatch expected %h actual %h",
                             $time, exp_r.mapped, mapped_value);
                    failures++;
                end
                if (running_minimum !== exp_r.minimum)
                begin
                    $display("%0t: running_minimum mismatch expected %h actual %h",
                             $time, exp_r.minimum, running_minimum);
                    failures++;
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog: too long without any accepted beat
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial
    begin : main_seq
        int e;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        stages_in_use = CFG_STAGES_RESET;
        item_valid    = 1'b0;
        command       = CMD_CLEAR;
        stage_index   = '0;
        entry_index   = '0;
        dest_start    = '0;
        source_start  = '0;
        range_length  = '0;
        query_value   = '0;
        failures      = 0;
        idle_on       = 1'b1;
        win_base      = '0;
        for (e = 0; e < N_ENTRIES; e++)
        begin
            tbl_dst[e]   = '0;
            tbl_src[e]   = '0;
            tbl_len[e]   = '0;
            tbl_valid[e] = 1'b0;
        end
        low_water       = '1;
        cur_stage_count = CFG_STAGES_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_tables();
        test_directed_cases();
        test_stage_counts();
        test_drain_pause();
        test_random_traffic();

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            failures++;
        end
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
